// File: sv/msp_pkg.sv
// Shared types and constants for the MIDI SysEx 8-to-7-bit packer.
package msp_pkg;

    localparam int GROUP_LEN  = 7;
    localparam int CHAIN_LEN  = GROUP_LEN + 1;
    localparam int DATA_W     = 7;
    localparam int FILL_W     = 3;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(GROUP_LEN - 1);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              glast;
        logic              mlast;
    } t_payload;

    typedef struct packed {
        logic     valid;
        t_payload payload;
    } t_slot;

endpackage

// File: sv/msp_cell.sv
// One cell of the output chain: holds one word, takes the load word on a load and its neighbor's word on a shift.
module msp_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_shift,
    input  msp_pkg::t_slot i_load_slot,
    input  msp_pkg::t_slot i_next_slot,
    output msp_pkg::t_slot o_slot
);

    logic              r_valid;
    msp_pkg::t_payload r_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_slot.valid;
        end else if (i_shift) begin
            r_valid <= i_next_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_payload <= i_load_slot.payload;
        end else if (i_shift) begin
            r_payload <= i_next_slot.payload;
        end
    end

    assign o_slot.valid   = r_valid;
    assign o_slot.payload = r_payload;

endmodule

// File: sv/midi_sysex_7bit_packer_top.sv
// Top level of the MIDI SysEx 8-to-7-bit packer.
// Input words are taken one per cycle while a group of up to seven bytes is being
// collected. The word that completes a group (the seventh byte, or any byte marked
// with tlast) holds the input off until the group moves into the output chain of
// eight cells, which happens as soon as that chain holds at most the word leaving it.
// The chain then sends the header and the n stored bytes, one word per cycle while
// the receiver holds tready high, so a group of n bytes gives n+1 output words and a
// stream of full groups is paced by the single output word per cycle.
module midi_sysex_7bit_packer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [msp_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                               i_s_axis_tlast,  // end_of_message
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [msp_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // [6:0] packed_byte, [7] zero
    output logic                               o_m_axis_tuser,  // group_last
    output logic                               o_m_axis_tlast   // message_last
);

    logic [msp_pkg::DATA_W-1:0] r_store [msp_pkg::GROUP_LEN];
    logic [msp_pkg::DATA_W-1:0] r_top;
    logic [msp_pkg::DATA_W-1:0] n_top;
    logic [msp_pkg::FILL_W-1:0] r_fill;
    logic [msp_pkg::FILL_W-1:0] r_n;
    logic                       r_eom;
    logic                       r_pend;

    logic                       in_acc;
    logic                       flush;
    logic                       pop;
    logic                       load;

    msp_pkg::t_slot             chain     [msp_pkg::CHAIN_LEN];
    msp_pkg::t_slot             next_slot [msp_pkg::CHAIN_LEN];
    msp_pkg::t_slot             load_slot [msp_pkg::CHAIN_LEN];

    assign o_s_axis_tready = !r_pend;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign flush           = i_s_axis_tlast || (r_fill == msp_pkg::LAST_SLOT);

    assign pop  = chain[0].valid && i_m_axis_tready;
    assign load = r_pend && !chain[1].valid && (!chain[0].valid || pop);

    always_comb begin
        n_top = (r_fill == '0) ? '0 : r_top;
        n_top[r_fill] = i_s_axis_tdata[msp_pkg::IN_TDATA_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pend <= 1'b0;
        end else begin
            if (in_acc) begin
                if (flush) begin
                    r_fill <= '0;
                    r_pend <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (load) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_store[r_fill] <= i_s_axis_tdata[msp_pkg::DATA_W-1:0];
            r_top           <= n_top;
            r_n             <= r_fill + 1'b1;
            r_eom           <= i_s_axis_tlast;
        end
    end

    always_comb begin
        load_slot[0].valid         = 1'b1;
        load_slot[0].payload.data  = r_top;
        load_slot[0].payload.glast = 1'b0;
        load_slot[0].payload.mlast = 1'b0;
        for (int k = 1; k < msp_pkg::CHAIN_LEN; k++) begin
            load_slot[k].valid         = (msp_pkg::FILL_W'(k) <= r_n);
            load_slot[k].payload.data  = r_store[k-1];
            load_slot[k].payload.glast = (msp_pkg::FILL_W'(k) == r_n);
            load_slot[k].payload.mlast = (msp_pkg::FILL_W'(k) == r_n) && r_eom;
        end
    end

    generate
        for (genvar g = 0; g < msp_pkg::CHAIN_LEN; g++) begin : g_chain
            if (g == msp_pkg::CHAIN_LEN - 1) begin : g_tail
                assign next_slot[g] = '0;
            end else begin : g_body
                assign next_slot[g] = chain[g+1];
            end

            msp_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_load      (load),
                .i_shift     (pop),
                .i_load_slot (load_slot[g]),
                .i_next_slot (next_slot[g]),
                .o_slot      (chain[g])
            );
        end
    endgenerate

    assign o_m_axis_tvalid = chain[0].valid;
    assign o_m_axis_tdata  = {1'b0, chain[0].payload.data};
    assign o_m_axis_tuser  = chain[0].payload.glast;
    assign o_m_axis_tlast  = chain[0].payload.mlast;

endmodule

// File: sv/msp_checker.sv
// Port-level checks for the MIDI SysEx 8-to-7-bit packer, bound to its top level.
module msp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            i_s_axis_tlast,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [msp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("Stalled output word changed.");

    a_msg_end_is_group_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("Message end without group end.");

    a_seven_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[msp_pkg::OUT_TDATA_W-1])
        else $error("Output word has its top bit set.");

    a_flush_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("Input taken while a message end is still held.");

    // In the cycle after the flushed group is held, a valid output word is shown (that group's or an older one).
    a_flush_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> ##1 o_m_axis_tvalid)
        else $error("No output word after a message end.");

endmodule

bind midi_sysex_7bit_packer_top msp_checker u_msp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: tb/msp_packer_checker.sv
// Checker that predicts the packed output words of the SysEx packer and compares them.
module msp_packer_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    input  logic                                      i_s_tready,
    input  logic [msp_pkg::IN_TDATA_W-1:0]            i_s_tdata,
    input  logic                                      i_s_tlast,
    input  logic                                      i_m_tvalid,
    input  logic                                      i_m_tready,
    input  logic [msp_pkg::OUT_TDATA_W-1:0]           i_m_tdata,
    input  logic                                      i_m_tuser,
    input  logic                                      i_m_tlast,
    output int                                        o_fail_count,
    output int                                        o_pending
);

    logic [msp_pkg::DATA_W-1:0] group_bytes [msp_pkg::GROUP_LEN];
    logic [msp_pkg::DATA_W-1:0] header_bits;
    logic [msp_pkg::FILL_W-1:0] fill;
    msp_pkg::t_payload          words_due [$];
    int                         fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
        header_bits  = '0;
        fill         = '0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: output word %s mismatch: got %h, want %h", $time, what, got, want);
        fails++;
    endtask

    task automatic pack_byte(input logic [msp_pkg::IN_TDATA_W-1:0] b, input logic eom);
        int unsigned       pos;
        int unsigned       n;
        msp_pkg::t_payload w;
        pos = 32'(fill);
        group_bytes[pos] = b[msp_pkg::DATA_W-1:0];
        if (b[msp_pkg::IN_TDATA_W-1]) begin
            header_bits[pos] = 1'b1;
        end
        n = pos + 1;
        if (n < msp_pkg::GROUP_LEN && !eom) begin
            fill = msp_pkg::FILL_W'(n);
        end else begin
            w.data  = header_bits;
            w.glast = 1'b0;
            w.mlast = 1'b0;
            words_due.push_back(w);
            for (int k = 0; k < n; k++) begin
                w.data  = group_bytes[k];
                w.glast = (k + 1 == n);
                w.mlast = (k + 1 == n) && eom;
                words_due.push_back(w);
            end
            header_bits = '0;
            fill        = '0;
        end
    endtask

    task automatic check_word();
        msp_pkg::t_payload w;
        if (words_due.size() == 0) begin
            report_mismatch("without expectation", i_m_tdata, 8'h00);
            return;
        end
        w = words_due.pop_front();
        if (i_m_tdata[msp_pkg::DATA_W-1:0] !== w.data) begin
            report_mismatch("packed_byte", 8'(i_m_tdata[msp_pkg::DATA_W-1:0]), 8'(w.data));
        end
        if (i_m_tdata[msp_pkg::OUT_TDATA_W-1:msp_pkg::DATA_W] !== '0) begin
            report_mismatch("pad bit",
                            8'(i_m_tdata[msp_pkg::OUT_TDATA_W-1:msp_pkg::DATA_W]), 8'h00);
        end
        if (i_m_tuser !== w.glast) begin
            report_mismatch("group_last", 8'(i_m_tuser), 8'(w.glast));
        end
        if (i_m_tlast !== w.mlast) begin
            report_mismatch("message_last", 8'(i_m_tlast), 8'(w.mlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            words_due.delete();
            header_bits = '0;
            fill        = '0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_word();
            end
            if (i_s_tvalid && i_s_tready) begin
                pack_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending    = words_due.size();
        o_fail_count = fails;
    end

endmodule

// File: tb/testbench.sv
// Top of the packer testbench: clock, reset, stream stimulus, receiver stalls and verdict.
module testbench;

    localparam logic [8:0] DIRECTED [22] = '{
        9'h100, 9'h1ff,
        9'h0ff, 9'h0ff, 9'h080, 9'h07f, 9'h0ff, 9'h001, 9'h0fe,
        9'h180,
        9'h07f, 9'h080, 9'h040, 9'h0bf, 9'h020, 9'h0df, 9'h1aa,
        9'h07f, 9'h080, 9'h101,
        9'h055, 9'h1aa
    };

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [msp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [msp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    int fail_count;
    int pending;
    int tx_idle_pct  = 27;
    int rx_idle_pct  = 45;
    bit hold_trigger = 1'b0;
    int bytes_sent   = 0;

    midi_sysex_7bit_packer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    msp_packer_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_word(input logic [msp_pkg::IN_TDATA_W-1:0] b, input logic last);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end while (!taken);
        bytes_sent++;
    endtask

    task automatic send_message(input int len);
        logic [msp_pkg::IN_TDATA_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(7))
                0: b = 8'h00;
                1: b = 8'hff;
                2: b = 8'h80;
                3: b = 8'h7f;
                default: b = msp_pkg::IN_TDATA_W'($urandom_range(255));
            endcase
            send_word(b, i == len - 1);
        end
    endtask

    task automatic send_random_messages(input int target);
        int len;
        while (bytes_sent < target) begin
            case ($urandom_range(9))
                0: len = 1;
                1: len = msp_pkg::GROUP_LEN;
                2: len = 2 * msp_pkg::GROUP_LEN;
                3: len = $urandom_range(15, 30);
                default: len = $urandom_range(1, 10);
            endcase
            send_message(len);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i][7:0], DIRECTED[i][8]);
        end
        hold_trigger = 1'b1;
        send_random_messages(60);

        tx_idle_pct = 45;
        rx_idle_pct = 27;
        send_random_messages(110);

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_trigger = 1'b1;
        send_random_messages(160);

        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_trigger) begin
                hold_trigger = 1'b0;
                hold_left    = 90;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
